>>> src/qrs_pkg.sv
// Package for the quadratic root solver: widths, codes and shared constants.
package qrs_pkg;
    localparam int COEF_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int TOL_WIDTH      = 24;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 24'd17;

    typedef enum logic [1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2,
        CNT_ANY  = 2'd3
    } t_count;
endpackage

>>> src/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
//
// Solves a*x^2 + b*x + c = 0 for one coefficient word per cycle in signed
// fixed point (Q12.12 by default). The pipeline forms the exact
// discriminant, classifies it against the zero tolerance, takes an integer
// square root one result bit per stage, and then runs two dividers, one bit
// per stage, for the two roots. The registers from the accepting edge to the
// result word are these:
// three stages form the products, the discriminant and the case,
// COEF_WIDTH + 2 stages take the square root, COEF_WIDTH + FRAC_BITS + 4
// stages run the dividers, and the last is the output register. The
// dividers hold most of those stages. Throughput is one word per cycle. The whole
// pipeline advances when the output register is empty or being taken, so
// a stall on the output holds every stage and nothing is lost or repeated.
// The tolerance register may only be written while the pipeline is empty.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qrs_pkg::TOL_WIDTH-1:0]       i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_a,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_b,
    input  logic signed [COEF_WIDTH-1:0]        i_coef_c,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_root_count,
    output logic signed [COEF_WIDTH-1:0]        o_root_first,
    output logic signed [COEF_WIDTH-1:0]        o_root_second,
    output logic                                o_saturated
);
    import qrs_pkg::*;

    localparam int CW    = COEF_WIDTH;
    localparam int DW    = 2 * CW + 3;          // discriminant, signed
    localparam int SW    = CW + 2;              // square root magnitude
    localparam int SQ_N  = (DW - 1 + 1) / 2;    // root bits
    localparam int NW    = CW + 3 + FRAC_BITS;  // numerator after scaling
    localparam int DENW  = CW + 2;              // denominator 2a
    localparam int TAGW  = 2 + 1;               // count, dummy flag

    logic adv;
    logic r_out_vld;
    assign adv     = !r_out_vld || i_ready;
    assign o_ready = adv;

    logic [TOL_WIDTH-1:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Stage 1: products b*b and a*c.
    logic                 r1_vld;
    logic signed [CW-1:0] r1_a, r1_b, r1_c;
    logic signed [2*CW-1:0] r1_bb, r1_ac;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_a  <= i_coef_a;
            r1_b  <= i_coef_b;
            r1_c  <= i_coef_c;
            r1_bb <= (2*CW)'(i_coef_b) * (2*CW)'(i_coef_b);
            r1_ac <= (2*CW)'(i_coef_a) * (2*CW)'(i_coef_c);
        end
    end

    // Stage 2: discriminant; its magnitude is formed combinationally from it.
    logic                 r2_vld;
    logic signed [CW-1:0] r2_a, r2_b, r2_c;
    logic signed [DW-1:0] r2_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_a <= r1_a;
            r2_b <= r1_b;
            r2_c <= r1_c;
            r2_d <= DW'(r1_bb) - (DW'(r1_ac) <<< 2);
        end
    end

    // Stage 3: classify the case.
    logic [DW-1:0] d_mag;
    logic          tol_hit;
    assign d_mag   = r2_d[DW-1] ? DW'(-r2_d) : DW'(r2_d);
    assign tol_hit = d_mag <= DW'(r_tol);

    typedef enum logic [2:0] {
        K_LIN = 3'd0, K_DEG = 3'd1, K_DBL = 3'd2, K_NEG = 3'd3, K_TWO = 3'd4
    } t_kind;

    logic                 r3_vld;
    t_kind                r3_kind;
    t_count               r3_cnt;
    logic signed [CW-1:0] r3_a, r3_b, r3_c;
    logic [DW-2:0]        r3_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_a <= r2_a;
            r3_b <= r2_b;
            r3_c <= r2_c;
            r3_d <= r2_d[DW-2:0];
            priority if (r2_a == '0 && r2_b == '0) begin
                r3_kind <= K_DEG;
                r3_cnt  <= (r2_c == '0) ? CNT_ANY : CNT_NONE;
            end else if (r2_a == '0) begin
                r3_kind <= K_LIN;
                r3_cnt  <= CNT_ONE;
            end else if (tol_hit) begin
                r3_kind <= K_DBL;
                r3_cnt  <= CNT_ONE;
            end else if (r2_d[DW-1]) begin
                r3_kind <= K_NEG;
                r3_cnt  <= CNT_NONE;
            end else begin
                r3_kind <= K_TWO;
                r3_cnt  <= CNT_TWO;
            end
        end
    end

    // Square root pipeline, one result bit per stage.
    logic [SQ_N:0]        sq_vld;
    logic [2*SQ_N-1:0]    sq_rad [SQ_N+1];
    logic [SW-1:0]        sq_root[SQ_N+1];
    logic [SW+1:0]        sq_rem [SQ_N+1];
    t_kind                sq_kind[SQ_N+1];
    t_count               sq_cnt [SQ_N+1];
    logic signed [CW-1:0] sq_a [SQ_N+1];
    logic signed [CW-1:0] sq_b [SQ_N+1];
    logic signed [CW-1:0] sq_c [SQ_N+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            sq_vld <= '0;
        end else if (adv) begin
            sq_vld <= {sq_vld[SQ_N-1:0], r3_vld};
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            sq_rad[0]  <= (2*SQ_N)'(r3_d);
            sq_root[0] <= '0;
            sq_rem[0]  <= '0;
            sq_kind[0] <= r3_kind;
            sq_cnt[0]  <= r3_cnt;
            sq_a[0]    <= r3_a;
            sq_b[0]    <= r3_b;
            sq_c[0]    <= r3_c;
        end
    end
    for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
        logic [SW+1:0] rem_sh;
        logic [SW+2:0] trial;
        assign rem_sh = {sq_rem[g][SW-1:0], sq_rad[g][2*SQ_N-1 -: 2]};
        assign trial  = {1'b0, rem_sh} - {1'b0, sq_root[g][SW-1:0], 2'b01};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                sq_rad[g+1] <= {sq_rad[g][2*SQ_N-3:0], 2'b00};
                if (!trial[SW+2]) begin
                    sq_rem[g+1]  <= trial[SW+1:0];
                    sq_root[g+1] <= {sq_root[g][SW-2:0], 1'b1};
                end else begin
                    sq_rem[g+1]  <= rem_sh;
                    sq_root[g+1] <= {sq_root[g][SW-2:0], 1'b0};
                end
                sq_kind[g+1] <= sq_kind[g];
                sq_cnt[g+1]  <= sq_cnt[g];
                sq_a[g+1]    <= sq_a[g];
                sq_b[g+1]    <= sq_b[g];
                sq_c[g+1]    <= sq_c[g];
            end
        end
    end

    // Operand selection for the two dividers.
    logic signed [NW-1:0]   num1, num2;
    logic signed [DENW-1:0] den;
    logic                   has_div;
    always_comb begin
        logic signed [CW+2:0] s, nb, n1, n2;
        s  = (CW+3)'(signed'({1'b0, sq_root[SQ_N]}));
        nb = -(CW+3)'(sq_b[SQ_N]);
        n1 = nb + s;
        n2 = nb - s;
        den     = (DENW)'(sq_a[SQ_N]) <<< 1;
        has_div = 1'b1;
        unique case (sq_kind[SQ_N])
            K_LIN: begin
                n1  = -(CW+3)'(sq_c[SQ_N]);
                n2  = '0;
                den = (DENW)'(sq_b[SQ_N]);
            end
            K_DBL: begin
                n1 = nb;
                n2 = '0;
            end
            K_TWO: begin
            end
            default: begin
                n1      = '0;
                n2      = '0;
                den     = DENW'(1);
                has_div = 1'b0;
            end
        endcase
        num1 = NW'(n1) <<< FRAC_BITS;
        num2 = NW'(n2) <<< FRAC_BITS;
    end

    logic                 dv1_vld, dv2_vld;
    logic signed [CW-1:0] q1, q2;
    logic                 s1, s2;
    logic [TAGW-1:0]      tag1, tag2;

    qrs_divider #(.NUM_W(NW), .DEN_W(DENW), .OUT_W(CW), .TAG_W(TAGW)) u_div_first (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
        .i_valid(sq_vld[SQ_N]), .i_num(num1), .i_den(den),
        .i_tag({sq_cnt[SQ_N], has_div}),
        .o_valid(dv1_vld), .o_quo(q1), .o_sat(s1), .o_tag(tag1)
    );
    qrs_divider #(.NUM_W(NW), .DEN_W(DENW), .OUT_W(CW), .TAG_W(TAGW)) u_div_second (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv),
        .i_valid(sq_vld[SQ_N]), .i_num(num2), .i_den(den),
        .i_tag({sq_cnt[SQ_N], has_div}),
        .o_valid(dv2_vld), .o_quo(q2), .o_sat(s2), .o_tag(tag2)
    );

    // Output register. Roots not reported read as zero.
    t_count               cnt_o;
    assign cnt_o = t_count'(tag1[TAGW-1:1]);

    logic [1:0]           r_cnt;
    logic signed [CW-1:0] r_r1, r_r2;
    logic                 r_sat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= dv1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cnt <= cnt_o;
            unique case (cnt_o)
                CNT_ONE: begin
                    r_r1  <= q1;
                    r_r2  <= '0;
                    r_sat <= s1;
                end
                CNT_TWO: begin
                    r_r1  <= q1;
                    r_r2  <= q2;
                    r_sat <= s1 | s2;
                end
                default: begin
                    r_r1  <= '0;
                    r_r2  <= '0;
                    r_sat <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid       = r_out_vld;
    assign o_root_count  = r_cnt;
    assign o_root_first  = r_r1;
    assign o_root_second = r_r2;
    assign o_saturated   = r_sat;

`ifndef ASSERT_OFF
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv1_vld == dv2_vld && (!dv1_vld || tag1 == tag2))
        else $error("root dividers out of step");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_root_first) && $stable(o_root_count))
        else $error("output word changed while stalled");
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_count == CNT_NONE || o_root_count == CNT_ANY)
        |-> o_root_first == '0 && o_root_second == '0 && !o_saturated)
        else $error("root reported without a count");
    a_div_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv1_vld && (cnt_o == CNT_ONE || cnt_o == CNT_TWO) |-> tag1[0])
        else $error("counted root with no division");
`endif
endmodule

>>> src/qrs_divider.sv
// Pipelined restoring divider with signed fixup and saturation, one quotient bit per stage.
module qrs_divider #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 26,
    parameter int OUT_W  = 24,
    parameter int TAG_W  = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0]        i_tag,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_quo,
    output logic                    o_sat,
    output logic [TAG_W-1:0]        o_tag
);
    localparam int STAGES = NUM_W;

    logic [STAGES:0]               r_vld;
    logic [NUM_W-1:0]              r_quo [STAGES+1];
    logic [DEN_W:0]                r_rem [STAGES+1];
    logic [DEN_W-1:0]              r_den [STAGES+1];
    logic                          r_neg [STAGES+1];
    logic [TAG_W-1:0]              r_tag [STAGES+1];

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             out_vld;
    logic [OUT_W-1:0] out_quo;
    logic             out_sat;
    logic [TAG_W-1:0] out_tag;

    assign num_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign den_mag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo[0] <= num_mag;
            r_rem[0] <= '0;
            r_den[0] <= den_mag;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_tag[0] <= i_tag;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_step
        logic [DEN_W+1:0] trial;
        logic [DEN_W:0]   shifted;
        assign shifted = {r_rem[g][DEN_W-1:0], r_quo[g][NUM_W-1]};
        assign trial   = {1'b0, shifted} - {2'b00, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!trial[DEN_W+1]) begin
                    r_rem[g+1] <= trial[DEN_W:0];
                    r_quo[g+1] <= {r_quo[g][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= shifted;
                    r_quo[g+1] <= {r_quo[g][NUM_W-2:0], 1'b0};
                end
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    // Saturation check on the quotient magnitude.
    always_comb begin
        logic [NUM_W-1:0] q;
        logic             big;
        q = r_quo[STAGES];
        if (r_neg[STAGES]) begin
            big = q > NUM_W'({1'b1, {(OUT_W-1){1'b0}}});
            out_quo = big ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-q);
        end else begin
            big = q > NUM_W'({1'b0, {(OUT_W-1){1'b1}}});
            out_quo = big ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(q);
        end
        out_sat = big;
        out_vld = r_vld[STAGES];
        out_tag = r_tag[STAGES];
    end

    assign o_valid = out_vld;
    assign o_quo   = out_quo;
    assign o_sat   = out_sat;
    assign o_tag   = out_tag;
endmodule
